// ===== rtl/ppc_pkg.sv =====
// Shared types and constants for the polygon plane clipper.
`default_nettype none
package ppc_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VIDX_W       = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int RESULT_CAP   = 32;
  localparam int RIDX_W       = $clog2(RESULT_CAP);
  localparam int TOT_W        = ($clog2(2 * MAX_VERTICES + 1) > RIDX_W + 1) ?
                                $clog2(2 * MAX_VERTICES + 1) : RIDX_W + 1;
  localparam int FRAC_W       = 24;
  localparam int PH_W         = 5;
  localparam int DW           = 66;   // plane distance, signed Q34.32
  localparam int QW           = 68;   // divider remainder and divisor
  localparam int MW           = 34;   // multiplier operand width
  localparam int PW           = 2 * MW;
  localparam int VW           = 96;
  localparam int CFG_IDX_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = CFG_IDX_W'(3);

  typedef struct packed {
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               last_vertex;
  } vertex_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               end_of_polygon;
    logic               kept;
    logic               no_vertex;
    logic               overflowed;
  } result_t;

  typedef enum logic [1:0] {ACC_NONE, ACC_INIT, ACC_ADD, ACC_D2} acc_op_t;
  typedef enum logic [2:0] {MUL_DX, MUL_DY, MUL_DZ, MUL_IX, MUL_IY, MUL_IZ} mul_op_t;
  typedef enum logic [1:0] {CW_NONE, CW_X, CW_Y, CW_Z} cw_op_t;

  typedef struct packed {
    logic              st_we;
    logic [VIDX_W-1:0] st_waddr;
    logic [VIDX_W-1:0] st_raddr;
    logic              lat_p2;
    mul_op_t           mul_op;
    acc_op_t           acc_op;
    cw_op_t            cw_op;
    logic              shift;
    logic              div_init;
    logic              div_step;
    logic              res_we;
    logic              res_sel_c;
    logic [RIDX_W-1:0] res_waddr;
    logic [RIDX_W-1:0] res_raddr;
    logic              out_end;
    logic              out_kept;
    logic              out_none;
    logic              out_ovf;
  } ppc_cmd_t;

  typedef struct packed {
    logic d1_neg;
    logic d1_zero;
    logic d2_neg;
    logic d2_zero;
    logic f_zero;
  } ppc_status_t;

endpackage
`default_nettype wire

// ===== rtl/ppc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ppc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/ppc_datapath.sv =====
// Datapath: plane registers, vertex and result stores, MAC, divider, interpolation.
`default_nettype none
module ppc_datapath
  import ppc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire vertex_in_t           item,
  input  wire ppc_cmd_t             cmd,
  output ppc_status_t               status,
  output result_t                   result
);

  logic signed [31:0] normal_x, normal_y, normal_z, plane_offset;
  logic [VW-1:0] st_q, res_q, res_wdata;
  logic signed [31:0] p1x, p1y, p1z, p2x, p2y, p2z, cx, cy, cz;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [DW-1:0] acc, d1, d2, off_term;
  logic [QW-1:0] num, den, abs1, abs2, num_sh;
  logic [FRAC_W-1:0] frac;
  logic signed [PW-1:0] rnd, rsh;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x     <= '0;
      normal_y     <= '0;
      normal_z     <= 32'sd65536;
      plane_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NORMAL_X:     normal_x     <= cfg_data;
        REG_NORMAL_Y:     normal_y     <= cfg_data;
        REG_NORMAL_Z:     normal_z     <= cfg_data;
        REG_PLANE_OFFSET: plane_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  ppc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vstore (
    .clk(clk), .we(cmd.st_we), .waddr(cmd.st_waddr),
    .wdata({item.coord_x, item.coord_y, item.coord_z}),
    .raddr(cmd.st_raddr), .rdata(st_q)
  );

  assign res_wdata = cmd.res_sel_c ? {cx, cy, cz} : {p1x, p1y, p1z};

  ppc_ram #(.WIDTH(VW), .DEPTH(RESULT_CAP)) u_rstore (
    .clk(clk), .we(cmd.res_we), .waddr(cmd.res_waddr), .wdata(res_wdata),
    .raddr(cmd.res_raddr), .rdata(res_q)
  );

  // select multiplier operands
  always_comb begin
    case (cmd.mul_op)
      MUL_DX: begin mul_a = MW'(normal_x); mul_b = MW'(p2x); end
      MUL_DY: begin mul_a = MW'(normal_y); mul_b = MW'(p2y); end
      MUL_DZ: begin mul_a = MW'(normal_z); mul_b = MW'(p2z); end
      MUL_IX: begin mul_a = MW'({1'b0, frac}); mul_b = MW'(p2x) - MW'(p1x); end
      MUL_IY: begin mul_a = MW'({1'b0, frac}); mul_b = MW'(p2y) - MW'(p1y); end
      MUL_IZ: begin mul_a = MW'({1'b0, frac}); mul_b = MW'(p2z) - MW'(p1z); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign off_term = {{(DW-48){plane_offset[31]}}, plane_offset, 16'b0};
  assign abs1     = QW'(d1[DW-1] ? -d1 : d1);
  assign abs2     = QW'(d2[DW-1] ? -d2 : d2);
  assign num_sh   = {num[QW-2:0], 1'b0};
  assign rnd      = prod + (PW'(1) <<< 23);
  assign rsh      = rnd >>> 24;

  // multiply, accumulate, divide and interpolate
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.lat_p2) begin
      {p2x, p2y, p2z} <= st_q;
    end
    case (cmd.acc_op)
      ACC_INIT: acc <= off_term + DW'(prod);
      ACC_ADD:  acc <= acc + DW'(prod);
      ACC_D2:   d2  <= acc + DW'(prod);
      default: ;
    endcase
    if (cmd.shift) begin
      {p1x, p1y, p1z} <= {p2x, p2y, p2z};
      d1 <= d2;
    end
    if (cmd.div_init) begin
      num  <= abs1;
      den  <= abs1 + abs2;
      frac <= '0;
    end else if (cmd.div_step) begin
      if (num_sh >= den) begin
        num  <= num_sh - den;
        frac <= {frac[FRAC_W-2:0], 1'b1};
      end else begin
        num  <= num_sh;
        frac <= {frac[FRAC_W-2:0], 1'b0};
      end
    end
    case (cmd.cw_op)
      CW_X: cx <= p1x + rsh[31:0];
      CW_Y: cy <= p1y + rsh[31:0];
      CW_Z: cz <= p1z + rsh[31:0];
      default: ;
    endcase
  end

  assign status.d1_neg  = d1[DW-1];
  assign status.d1_zero = (d1 == '0);
  assign status.d2_neg  = d2[DW-1];
  assign status.d2_zero = (d2 == '0);
  assign status.f_zero  = (frac == '0);

  // drive result fields; a rejection carries zero coordinates
  always_comb begin
    {result.out_x, result.out_y, result.out_z} = cmd.out_none ? '0 : res_q;
    result.end_of_polygon = cmd.out_end;
    result.kept           = cmd.out_kept;
    result.no_vertex      = cmd.out_none;
    result.overflowed     = cmd.out_ovf;
  end

endmodule
`default_nettype wire

// ===== rtl/ppc_ctrl.sv =====
// Controller: loading, clipping sequence and result emission.
`default_nettype none
module ppc_ctrl
  import ppc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire logic  last_vertex,
  input  wire ppc_status_t status,
  output logic       busy,
  output logic       result_valid,
  output ppc_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_LAT, S_DIST, S_EVAL, S_DIV, S_DIVCHK,
    S_INTERP, S_WRC, S_NEXT, S_FIN, S_EMIT, S_DRAIN
  } state_t;

  state_t state;
  logic [CNT_W-1:0] count, n, count_inc;
  logic [VIDX_W-1:0] v2, last_idx;
  logic [TOT_W-1:0] total, er, nres_m1;
  logic [PH_W-1:0] ph;
  logic first, ovf, kept_r, accept, full, crossing, cap_ok;
  logic out_end, out_kept, out_none, out_ovf;

  assign accept    = start && (state == S_IDLE);
  assign full      = (count == CNT_W'(MAX_VERTICES));
  assign count_inc = full ? count : count + 1'b1;
  assign last_idx  = (n == CNT_W'(2)) ? '0 : VIDX_W'(n - 1'b1);
  assign crossing  = (status.d1_neg != status.d2_neg) && !status.d1_zero && !status.d2_zero;
  assign cap_ok    = (total < TOT_W'(RESULT_CAP));
  assign nres_m1   = (cap_ok ? total : TOT_W'(RESULT_CAP)) - 1'b1;
  assign busy      = (state != S_IDLE);

  // decode commands
  always_comb begin
    cmd           = '0;
    cmd.mul_op    = MUL_DX;
    cmd.acc_op    = ACC_NONE;
    cmd.cw_op     = CW_NONE;
    cmd.st_we     = accept && !full;
    cmd.st_waddr  = VIDX_W'(count);
    cmd.st_raddr  = first ? VIDX_W'(n - 1'b1) : v2;
    cmd.res_waddr = total[RIDX_W-1:0];
    cmd.res_raddr = er[RIDX_W-1:0];
    cmd.out_end   = out_end;
    cmd.out_kept  = out_kept;
    cmd.out_none  = out_none;
    cmd.out_ovf   = out_ovf;
    case (state)
      S_LAT: cmd.lat_p2 = 1'b1;
      S_DIST: begin
        case (ph)
          PH_W'(0): cmd.mul_op = MUL_DX;
          PH_W'(1): begin cmd.mul_op = MUL_DY; cmd.acc_op = ACC_INIT; end
          PH_W'(2): begin cmd.mul_op = MUL_DZ; cmd.acc_op = ACC_ADD; end
          default: cmd.acc_op = ACC_D2;
        endcase
      end
      S_EVAL: begin
        cmd.div_init = 1'b1;
        cmd.res_we   = !status.d1_neg && cap_ok;
      end
      S_DIV: cmd.div_step = 1'b1;
      S_INTERP: begin
        case (ph)
          PH_W'(0): cmd.mul_op = MUL_IX;
          PH_W'(1): begin cmd.mul_op = MUL_IY; cmd.cw_op = CW_X; end
          PH_W'(2): begin cmd.mul_op = MUL_IZ; cmd.cw_op = CW_Y; end
          default: cmd.cw_op = CW_Z;
        endcase
      end
      S_WRC: begin
        cmd.res_we    = cap_ok;
        cmd.res_sel_c = 1'b1;
      end
      S_NEXT: cmd.shift = 1'b1;
      default: ;
    endcase
  end

  // hold state, counters and result flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      ovf          <= 1'b0;
      n            <= '0;
      v2           <= '0;
      total        <= '0;
      er           <= '0;
      ph           <= '0;
      first        <= 1'b0;
      kept_r       <= 1'b0;
      result_valid <= 1'b0;
      out_end      <= 1'b0;
      out_kept     <= 1'b0;
      out_none     <= 1'b0;
      out_ovf      <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            count <= count_inc;
            if (full) ovf <= 1'b1;
            if (last_vertex) begin
              n     <= count_inc;
              first <= 1'b1;
              total <= '0;
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_LAT;
        S_LAT: begin
          ph    <= '0;
          state <= S_DIST;
        end
        S_DIST: begin
          ph <= ph + 1'b1;
          if (ph == PH_W'(3)) state <= first ? S_NEXT : S_EVAL;
        end
        S_EVAL: begin
          if (!status.d1_neg) total <= total + 1'b1;
          ph    <= '0;
          state <= crossing ? S_DIV : S_NEXT;
        end
        S_DIV: begin
          ph <= ph + 1'b1;
          if (ph == PH_W'(FRAC_W - 1)) state <= S_DIVCHK;
        end
        S_DIVCHK: begin
          ph    <= '0;
          state <= status.f_zero ? S_NEXT : S_INTERP;
        end
        S_INTERP: begin
          ph <= ph + 1'b1;
          if (ph == PH_W'(3)) state <= S_WRC;
        end
        S_WRC: begin
          total <= total + 1'b1;
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (first) begin
            first <= 1'b0;
            v2    <= '0;
            state <= S_RD;
          end else if (v2 == last_idx) begin
            state <= S_FIN;
          end else begin
            v2    <= v2 + 1'b1;
            state <= S_RD;
          end
        end
        S_FIN: begin
          kept_r <= (total > TOT_W'(1));
          er     <= '0;
          if (total == '0) begin
            result_valid <= 1'b1;
            out_end      <= 1'b1;
            out_kept     <= 1'b0;
            out_none     <= 1'b1;
            out_ovf      <= ovf;
            state        <= S_DRAIN;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          result_valid <= 1'b1;
          out_end      <= (er == nres_m1);
          out_kept     <= kept_r;
          out_none     <= 1'b0;
          out_ovf      <= ovf;
          if (er == nres_m1) state <= S_DRAIN;
          else er <= er + 1'b1;
        end
        S_DRAIN: begin
          count <= '0;
          ovf   <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_valid_in_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (state == S_EMIT || state == S_DRAIN))
    else $error("result transfer outside emission");
  a_res_cap: assert property (@(posedge clk) disable iff (rst)
    cmd.res_we |-> (total < TOT_W'(RESULT_CAP)))
    else $error("result store written beyond capacity");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond store depth");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (ph < PH_W'(FRAC_W)))
    else $error("divider ran too many steps");
`endif

endmodule
`default_nettype wire

// ===== rtl/polygon_plane_clipper.sv =====
// Top level of the single-plane polygon clipper.
// Vertices load one per cycle while busy is low; the last vertex starts clipping.
// Clipping computes the first distance, then the distance of each edge; an edge that crosses
// the plane also runs a 24-step divider, a check, interpolation and a write (the last two
// are skipped if the fraction is 0). Results then stream one per cycle, with no stalls.
// Synchronous active-high reset clears the plane to z-normal, empty store, no flags.
`default_nettype none
module polygon_plane_clipper
  import ppc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire vertex_in_t           item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  output logic                      result_valid,
  output result_t                   result
);

  ppc_cmd_t    cmd;
  ppc_status_t status;

  assign cfg_ready = 1'b1;

  ppc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .last_vertex(item.last_vertex),
    .status(status), .busy(busy), .result_valid(result_valid), .cmd(cmd)
  );

  ppc_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .item(item), .cmd(cmd), .status(status), .result(result)
  );

endmodule
`default_nettype wire
